// ===== design/dsjq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsjq_pkg
// Shared codes, field widths and default sizes for the deadline job queue.
// ----------------------------------------------------------------------------
package dsjq_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int TIME_BITS_DEF   = 32;
   localparam int JOB_BITS_DEF    = 16;

   localparam int CMD_W    = 2;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;

   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_PAST      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_NOT_DUE   = 3'd5;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_res_type;

endpackage
`default_nettype wire

// ===== design/dsjq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsjq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dsjq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== design/dsjq_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsjq_cmp
// Shared magnitude/equality comparator used by the schedule, tick and remove operations.
// ----------------------------------------------------------------------------
module dsjq_cmp import dsjq_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  wire logic [WIDTH-1:0] op_a,
   input  wire logic [WIDTH-1:0] op_b,
   output cmp_res_type           res
);

   always_comb begin
      res.lt = op_a < op_b;
      res.eq = op_a == op_b;
   end

endmodule
`default_nettype wire

// ===== design/dsjq_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsjq_seq
// Command sequencer: walks the sorted slot RAM one entry per cycle through
// the shared comparator, shifts entries for insert/drop, drives result beats.
// ----------------------------------------------------------------------------
module dsjq_seq import dsjq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF,
   parameter int JOB_BITS    = JOB_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [CMD_W-1:0]               req_cmd,
   input  wire logic [JOB_BITS-1:0]            req_job,
   input  wire logic [TIME_BITS-1:0]           req_time,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [KIND_W-1:0]              rsp_kind,
   output logic      [STATUS_W-1:0]            rsp_status,
   output logic      [JOB_BITS-1:0]            rsp_job,
   output logic      [TIME_BITS-1:0]           rsp_time,
   output logic                                rsp_last,
   output logic                                wr_en,
   output logic      [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   output logic      [JOB_BITS+TIME_BITS-1:0]  wr_data,
   output logic      [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   input  wire logic [JOB_BITS+TIME_BITS-1:0]  rd_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (TIME_BITS > JOB_BITS) ? TIME_BITS : JOB_BITS;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SCHED     = 4'd1;
   localparam logic [3:0] S_INS       = 4'd2;
   localparam logic [3:0] S_INS_NEW   = 4'd3;
   localparam logic [3:0] S_TICK_HEAD = 4'd4;
   localparam logic [3:0] S_TICK_RUN  = 4'd5;
   localparam logic [3:0] S_EMIT      = 4'd6;
   localparam logic [3:0] S_COPY      = 4'd7;
   localparam logic [3:0] S_RM_SCAN   = 4'd8;
   localparam logic [3:0] S_RESP      = 4'd9;

   logic [3:0]           state_ff, state_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     run_ff, run_in;
   logic [CNT_W-1:0]     shift_ff, shift_in;
   logic [TIME_BITS-1:0] cur_ff, cur_in;
   logic [TIME_BITS-1:0] head_ff, head_in;
   logic [TIME_BITS-1:0] t_ff, t_in;
   logic [TIME_BITS-1:0] rmtime_ff, rmtime_in;
   logic [JOB_BITS-1:0]  job_ff, job_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic                 rsp_valid_ff;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [JOB_BITS-1:0]  rsp_job_ff, rsp_job_in;
   logic [TIME_BITS-1:0] rsp_time_ff, rsp_time_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 load;
   logic                 out_free;

   logic [CMP_W-1:0]     cmp_a, cmp_b;
   cmp_res_type          cmp;

   logic [TIME_BITS-1:0] rd_time;
   logic [JOB_BITS-1:0]  rd_job;
   logic [CNT_W-1:0]     idx_nxt;
   logic                 more;

   dsjq_cmp #(.WIDTH(CMP_W)) u_cmp (
      .op_a (cmp_a),
      .op_b (cmp_b),
      .res  (cmp)
   );

   assign rd_time  = rd_data[TIME_BITS-1:0];
   assign rd_job   = rd_data[TIME_BITS+JOB_BITS-1:TIME_BITS];
   assign idx_nxt  = CNT_W'(idx_ff) + CNT_W'(1);
   assign more     = idx_nxt < n_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_addr  = idx_in;

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      run_in        = run_ff;
      shift_in      = shift_ff;
      cur_in        = cur_ff;
      head_in       = head_ff;
      t_in          = t_ff;
      rmtime_in     = rmtime_ff;
      job_in        = job_ff;
      cmd_in        = cmd_ff;
      kind_in       = kind_ff;
      status_in     = status_ff;
      load          = 1'b0;
      rsp_kind_in   = kind_ff;
      rsp_status_in = status_ff;
      rsp_job_in    = '0;
      rsp_time_in   = '0;
      rsp_last_in   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = {job_ff, t_ff};
      cmp_a         = '0;
      cmp_b         = '0;
      req_ready     = state_ff == S_IDLE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               idx_in    = '0;
               cmd_in    = req_cmd;
               job_in    = req_job;
               t_in      = req_time;
               kind_in   = KIND_ACK;
               status_in = STAT_OK;
               case (req_cmd)
                  CMD_SCHEDULE: begin
                     state_in = S_SCHED;
                  end
                  CMD_TICK: begin
                     cur_in = req_time;
                     if (n_ff == '0) begin
                        status_in = STAT_NOT_DUE;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_TICK_HEAD;
                     end
                  end
                  CMD_REMOVE: begin
                     if (n_ff == '0) begin
                        status_in = STAT_NOT_FOUND;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_RM_SCAN;
                     end
                  end
                  default: begin
                     n_in     = '0;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SCHED: begin
            cmp_a = CMP_W'(t_ff);
            cmp_b = CMP_W'(cur_ff);
            if (cmp.lt) begin
               status_in = STAT_PAST;
               state_in  = S_RESP;
            end else if (&job_ff) begin
               status_in = STAT_INVALID;
               state_in  = S_RESP;
            end else if (n_ff == CNT_W'(QUEUE_DEPTH)) begin
               status_in = STAT_FULL;
               state_in  = S_RESP;
            end else if (n_ff == '0) begin
               state_in = S_INS_NEW;
            end else begin
               idx_in   = IDX_W'(n_ff - CNT_W'(1));
               state_in = S_INS;
            end
         end
         S_INS: begin
            cmp_a   = CMP_W'(t_ff);
            cmp_b   = CMP_W'(rd_time);
            wr_en   = 1'b1;
            wr_addr = IDX_W'(idx_nxt);
            if (cmp.lt) begin
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = S_INS_NEW;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end else begin
               n_in     = n_ff + CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_INS_NEW: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            n_in     = n_ff + CNT_W'(1);
            state_in = S_RESP;
         end
         S_TICK_HEAD: begin
            cmp_a = CMP_W'(cur_ff);
            cmp_b = CMP_W'(rd_time);
            if (cmp.lt) begin
               status_in = STAT_NOT_DUE;
               state_in  = S_RESP;
            end else begin
               head_in = rd_time;
               run_in  = CNT_W'(1);
               if (more) begin
                  idx_in   = IDX_W'(idx_nxt);
                  state_in = S_TICK_RUN;
               end else begin
                  idx_in   = '0;
                  state_in = S_EMIT;
               end
            end
         end
         S_TICK_RUN: begin
            cmp_a = CMP_W'(rd_time);
            cmp_b = CMP_W'(head_ff);
            if (cmp.eq && more) begin
               run_in = run_ff + CNT_W'(1);
               idx_in = IDX_W'(idx_nxt);
            end else begin
               if (cmp.eq) begin
                  run_in = run_ff + CNT_W'(1);
               end
               idx_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_kind_in   = KIND_FIRED;
               rsp_status_in = STAT_OK;
               rsp_job_in    = rd_job;
               rsp_time_in   = head_ff;
               rsp_last_in   = idx_nxt == run_ff;
               if (idx_nxt == run_ff) begin
                  shift_in = run_ff;
                  if (run_ff < n_ff) begin
                     idx_in   = IDX_W'(run_ff);
                     state_in = S_COPY;
                  end else begin
                     n_in     = '0;
                     state_in = S_IDLE;
                  end
               end else begin
                  idx_in = IDX_W'(idx_nxt);
               end
            end
         end
         S_COPY: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(CNT_W'(idx_ff) - shift_ff);
            wr_data = rd_data;
            if (more) begin
               idx_in = IDX_W'(idx_nxt);
            end else begin
               n_in     = n_ff - shift_ff;
               state_in = (cmd_ff == CMD_REMOVE) ? S_RESP : S_IDLE;
            end
         end
         S_RM_SCAN: begin
            cmp_a = CMP_W'(rd_job);
            cmp_b = CMP_W'(job_ff);
            if (cmp.eq) begin
               kind_in   = KIND_REMOVED;
               rmtime_in = rd_time;
               shift_in  = CNT_W'(1);
               if (more) begin
                  idx_in   = IDX_W'(idx_nxt);
                  state_in = S_COPY;
               end else begin
                  n_in     = n_ff - CNT_W'(1);
                  state_in = S_RESP;
               end
            end else if (more) begin
               idx_in = IDX_W'(idx_nxt);
            end else begin
               status_in = STAT_NOT_FOUND;
               state_in  = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               load = 1'b1;
               if (kind_ff == KIND_REMOVED) begin
                  rsp_job_in  = job_ff;
                  rsp_time_in = rmtime_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         idx_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         idx_ff   <= idx_in;
         cur_ff   <= cur_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      run_ff    <= run_in;
      shift_ff  <= shift_in;
      head_ff   <= head_in;
      t_ff      <= t_in;
      rmtime_ff <= rmtime_in;
      job_ff    <= job_in;
      cmd_ff    <= cmd_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      if (load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_status_ff <= rsp_status_in;
         rsp_job_ff    <= rsp_job_in;
         rsp_time_ff   <= rsp_time_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_job    = rsp_job_ff;
   assign rsp_time   = rsp_time_ff;
   assign rsp_last   = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_write_in_prefix: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(wr_addr) <= n_ff))
      else $error("slot write outside occupied prefix");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != S_IDLE))
      else $error("slot write while idle");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_NEW) |=> (n_ff == $past(n_ff) + CNT_W'(1)))
      else $error("insert did not grow queue");

endmodule
`default_nettype wire

// ===== design/deadline_sorted_job_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_sorted_job_queue_top
// Sorted timer queue of job ids keyed by start time, stream command port.
// ----------------------------------------------------------------------------
// Command flow: clear empties the queue and answers; schedule checks the request, then moves
//   later entries up one slot and writes the new entry; remove scans by job id and compacts
//   behind the hit; tick checks the head, counts the run sharing its time, then fires them.
// Throughput: one command at a time; the next beat is accepted the cycle after the last
//   response loads, or after a tick that leaves entries, once those entries are compacted.
// Reset empties the queue (fill count) and zeroes current time; no RAM sweep.
module deadline_sorted_job_queue_top import dsjq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF,
   parameter int JOB_BITS    = JOB_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // job_id, time_value
   input  wire logic [((JOB_BITS+TIME_BITS+7)/8)*8-1:0] req_tdata,
   // cmd
   input  wire logic [CMD_W-1:0] req_tuser,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // status, job_id_res, fire_time
   output logic [((STATUS_W+JOB_BITS+TIME_BITS+7)/8)*8-1:0] rsp_tdata,
   // kind
   output logic [KIND_W-1:0] rsp_tuser,
   output logic      rsp_tlast
);

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int ENTRY_W = JOB_BITS + TIME_BITS;
   localparam int RSP_W   = ((STATUS_W + JOB_BITS + TIME_BITS + 7) / 8) * 8;

   logic [STATUS_W-1:0]  rsp_status;
   logic [JOB_BITS-1:0]  rsp_job;
   logic [TIME_BITS-1:0] rsp_time;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [ENTRY_W-1:0]   rd_data;

   dsjq_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS),
      .JOB_BITS    (JOB_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser),
      .req_job    (req_tdata[JOB_BITS-1:0]),
      .req_time   (req_tdata[JOB_BITS+TIME_BITS-1:JOB_BITS]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_status (rsp_status),
      .rsp_job    (rsp_job),
      .rsp_time   (rsp_time),
      .rsp_last   (rsp_tlast),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   dsjq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tdata = RSP_W'({rsp_time, rsp_job, rsp_status});

endmodule
`default_nettype wire
